@@ sv/smvm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package smvm_pkg;

  localparam int unsigned ROW_W = 6;
  localparam int unsigned COL_W = 10;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned SUM_W = 48;
  localparam int unsigned TOL_W = 31;
  localparam int unsigned PROD_W = 2 * VAL_W;

  typedef enum logic [2:0] {
    MODE_CLEAR  = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_LOAD   = 3'd2,
    MODE_MULT   = 3'd3,
    MODE_SYM    = 3'd4
  } mode_e;

endpackage

`default_nettype wire

@@ sv/sparse_matrix_vector_multiply.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals
// command   in         start_i, busy_o, mode_i, row_index_i, col_index_i,
//                      entry_value_i, vector_value_i
// result    out        result_valid_o, out_row_o, product_value_o, symmetric_o,
//                      status_o, last_o
// config    in         cfg_valid_i, cfg_ready_o, cfg_data_i
//
// Clear, insert and vector load finish in the idle state and never raise busy.
// Multiply first clears every row sum, then takes each stored entry through the
// read, vector, multiply and accumulate states of the shared multiplier and
// accumulator, then reports each row up to the highest row used. Symmetry check
// compares each entry with earlier ones through the single entry memory port.
// Reset clears control state only; results cannot be stalled by the receiver.

module sparse_matrix_vector_multiply
  import smvm_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES   = 1024,
  parameter int unsigned MAX_ROWS      = 64,
  parameter int unsigned VECTOR_LENGTH = 1024
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  output logic                         busy_o,
  input  wire logic [2:0]              mode_i,
  input  wire logic [ROW_W-1:0]        row_index_i,
  input  wire logic [COL_W-1:0]        col_index_i,
  input  wire logic signed [VAL_W-1:0] entry_value_i,
  input  wire logic signed [VAL_W-1:0] vector_value_i,
  output logic                         result_valid_o,
  output logic [ROW_W-1:0]             out_row_o,
  output logic signed [SUM_W-1:0]      product_value_o,
  output logic                         symmetric_o,
  output logic                         status_o,
  output logic                         last_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [TOL_W-1:0]        cfg_data_i
);

  localparam int unsigned EIW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VIW = (VECTOR_LENGTH > 1) ? $clog2(VECTOR_LENGTH) : 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MCLR, S_MRD, S_MVEC, S_MMUL, S_MACC, S_MORD, S_MOUT,
    S_SIRD, S_SILAT, S_SJRD, S_SJCMP
  } state_e;

  state_e state_q;

  logic [ROW_W-1:0]        erow_mem [MAX_ENTRIES];
  logic [COL_W-1:0]        ecol_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] eval_mem [MAX_ENTRIES];
  logic signed [VAL_W-1:0] vec_mem  [VECTOR_LENGTH];
  logic signed [SUM_W-1:0] rs_mem   [MAX_ROWS];

  logic [CW-1:0]           cnt_q;
  logic [CW-1:0]           i_q;
  logic [CW-1:0]           j_q;
  logic [RCW-1:0]          r_q;
  logic [RCW-1:0]          nrows_q;
  logic [TOL_W-1:0]        tol_q;

  logic [ROW_W-1:0]        ent_row_q;
  logic [COL_W-1:0]        ent_col_q;
  logic signed [VAL_W-1:0] ent_val_q;
  logic signed [VAL_W-1:0] vec_q;
  logic signed [SUM_W-1:0] rs_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    col_ok_q;
  logic [ROW_W-1:0]        a_row_q;
  logic [COL_W-1:0]        a_col_q;
  logic signed [VAL_W-1:0] a_val_q;

  logic                    valid_q;
  logic [ROW_W-1:0]        orow_q;
  logic signed [SUM_W-1:0] oval_q;
  logic                    osym_q;
  logic                    ost_q;
  logic                    olast_q;

  logic                    accept;
  logic                    ins_ok;
  logic                    ent_we;
  logic                    vec_we;
  logic                    rs_we;
  logic [RW-1:0]           rs_waddr;
  logic signed [SUM_W-1:0] rs_wdata;
  logic [EIW-1:0]          ent_raddr;
  logic [RW-1:0]           rs_raddr;
  logic signed [SUM_W-1:0] term;
  logic signed [SUM_W:0]   sum_ext;
  logic signed [SUM_W-1:0] sum_sat;
  logic                    pair_match;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W:0]          diff_abs;
  logic                    too_far;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  assign ins_ok = (cnt_q != CW'(MAX_ENTRIES)) && (7'(row_index_i) < 7'(MAX_ROWS));
  assign ent_we = accept && (mode_i == MODE_INSERT) && ins_ok;
  assign vec_we = accept && (mode_i == MODE_LOAD)
                  && (32'(col_index_i) < 32'(VECTOR_LENGTH));

  assign term    = col_ok_q ? prod_q[PROD_W-1:16] : '0;
  assign sum_ext = {rs_q[SUM_W-1], rs_q} + {term[SUM_W-1], term};

  always_comb begin
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_sat = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  always_comb begin
    rs_we    = 1'b0;
    rs_waddr = r_q[RW-1:0];
    rs_wdata = '0;
    if (state_q == S_MCLR) begin
      rs_we = 1'b1;
    end else if (state_q == S_MACC) begin
      rs_we    = 1'b1;
      rs_waddr = RW'(ent_row_q);
      rs_wdata = sum_sat;
    end
  end

  assign ent_raddr = (state_q == S_SJRD) ? j_q[EIW-1:0] : i_q[EIW-1:0];
  assign rs_raddr  = (state_q == S_MMUL) ? RW'(ent_row_q) : r_q[RW-1:0];

  assign pair_match = ((ent_row_q == a_row_q) && (ent_col_q == a_col_q))
                      || ((COL_W'(ent_row_q) == a_col_q) && (ent_col_q == COL_W'(a_row_q)));
  assign diff       = {a_val_q[VAL_W-1], a_val_q} - {ent_val_q[VAL_W-1], ent_val_q};
  assign diff_abs   = diff[VAL_W] ? (VAL_W + 1)'(-diff) : diff;
  assign too_far    = diff_abs > (VAL_W + 1)'(tol_q);

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      erow_mem[cnt_q[EIW-1:0]] <= row_index_i;
      ecol_mem[cnt_q[EIW-1:0]] <= col_index_i;
      eval_mem[cnt_q[EIW-1:0]] <= entry_value_i;
    end
    ent_row_q <= erow_mem[ent_raddr];
    ent_col_q <= ecol_mem[ent_raddr];
    ent_val_q <= eval_mem[ent_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (vec_we) begin
      vec_mem[VIW'(col_index_i)] <= vector_value_i;
    end
    vec_q <= vec_mem[VIW'(ent_col_q)];
  end

  always_ff @(posedge clk_i) begin
    if (rs_we) begin
      rs_mem[rs_waddr] <= rs_wdata;
    end
    rs_q <= rs_mem[rs_raddr];
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= ent_val_q * vec_q;
    col_ok_q <= (32'(ent_col_q) < 32'(VECTOR_LENGTH));
    if (state_q == S_SILAT) begin
      a_row_q <= ent_row_q;
      a_col_q <= ent_col_q;
      a_val_q <= ent_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      r_q     <= '0;
      nrows_q <= '0;
      valid_q <= 1'b0;
      orow_q  <= '0;
      oval_q  <= '0;
      osym_q  <= 1'b0;
      ost_q   <= 1'b0;
      olast_q <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      orow_q  <= '0;
      oval_q  <= '0;
      osym_q  <= 1'b0;
      ost_q   <= 1'b0;
      olast_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (mode_i)
              MODE_CLEAR: begin
                cnt_q <= '0;
              end
              MODE_INSERT: begin
                valid_q <= 1'b1;
                olast_q <= 1'b1;
                ost_q   <= !ins_ok;
                if (ins_ok) begin
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              MODE_MULT: begin
                r_q     <= '0;
                nrows_q <= RCW'(1);
                state_q <= S_MCLR;
              end
              MODE_SYM: begin
                i_q     <= '0;
                state_q <= S_SIRD;
              end
              default: begin
              end
            endcase
          end
        end
        S_MCLR: begin
          if (r_q == RCW'(MAX_ROWS - 1)) begin
            i_q     <= '0;
            state_q <= S_MRD;
          end else begin
            r_q <= r_q + 1'b1;
          end
        end
        S_MRD: begin
          if (i_q == cnt_q) begin
            r_q     <= '0;
            state_q <= S_MORD;
          end else begin
            state_q <= S_MVEC;
          end
        end
        S_MVEC: begin
          if (RCW'(ent_row_q) + 1'b1 > nrows_q) begin
            nrows_q <= RCW'(ent_row_q) + 1'b1;
          end
          state_q <= S_MMUL;
        end
        S_MMUL: begin
          state_q <= S_MACC;
        end
        S_MACC: begin
          i_q     <= i_q + 1'b1;
          state_q <= S_MRD;
        end
        S_MORD: begin
          state_q <= S_MOUT;
        end
        S_MOUT: begin
          valid_q <= 1'b1;
          orow_q  <= ROW_W'(r_q);
          oval_q  <= rs_q;
          if (r_q + 1'b1 == nrows_q) begin
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            r_q     <= r_q + 1'b1;
            state_q <= S_MORD;
          end
        end
        S_SIRD: begin
          if (i_q == cnt_q) begin
            valid_q <= 1'b1;
            osym_q  <= 1'b1;
            olast_q <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_SILAT;
          end
        end
        S_SILAT: begin
          j_q     <= '0;
          state_q <= S_SJRD;
        end
        S_SJRD: begin
          if (j_q == i_q) begin
            i_q     <= i_q + 1'b1;
            state_q <= S_SIRD;
          end else begin
            state_q <= S_SJCMP;
          end
        end
        S_SJCMP: begin
          if (pair_match) begin
            if (too_far) begin
              valid_q <= 1'b1;
              olast_q <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_SIRD;
            end
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_SJRD;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o  = valid_q;
  assign out_row_o       = orow_q;
  assign product_value_o = oval_q;
  assign symmetric_o     = osym_q;
  assign status_o        = ost_q;
  assign last_o          = olast_q;

endmodule

`default_nettype wire
